/* hw/rtl/bitmap_extent_allocator_core_assert.svh */
// Assertion macros for the bitmap extent allocator.
`ifndef BITMAP_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BEA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bea: implication check failed");
`define BEA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bea: next-cycle check failed");
`else
`define BEA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BEA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/bea_pkg.sv */
// Types and constants shared by the bitmap extent allocator modules.
package bea_pkg;

   localparam int WORD_W = 64;
   localparam int LEN_W  = 13;
   localparam int ADDR_W = 48;
   localparam int BASE_W = 32;
   localparam int SH_W   = 6;
   localparam int WCNT_W = 8;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_BAD     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_BASE   = 2'd0,
      CSR_CHUNKS = 2'd1,
      CSR_LOG2   = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_CHK2,
      ST_SRD,
      ST_SEVAL,
      ST_ADDR,
      ST_WRD,
      ST_WWR,
      ST_FRD,
      ST_FEVAL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             hit;
      logic [5:0]       end_bit;
      logic [LEN_W-1:0] carry;
   } fit_res_type;

endpackage

/* hw/rtl/bea_ram.sv */
// Bitmap word store: one write port, one registered read port.
module bea_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] store_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bea_fit.sv */
// Per-word first-fit evaluation: finds where a free run of the wanted length ends.
module bea_fit import bea_pkg::*; (
   input  logic [WORD_W-1:0] used,
   input  logic [LEN_W-1:0]  carry,
   input  logic [LEN_W-1:0]  len,
   output fit_res_type       res
);

   logic [WORD_W-1:0]   free;
   logic [6:0]          tail_len;
   logic [6:0][127:0]   f;
   logic [127:0]        g;
   logic [WORD_W-1:0]   hits;
   logic [6:0]          tz;
   logic [6:0]          lz;
   logic [LEN_W:0]      k;
   logic [5:0]          first;

   always_comb begin
      free     = ~used;
      tail_len = (carry > LEN_W'(64)) ? 7'd64 : carry[6:0];
      for (int i = 0; i < 64; i++) begin
         f[0][i] = (i >= (64 - int'(tail_len)));
      end
      f[0][127:64] = free;
      for (int j = 1; j < 7; j++) begin
         f[j] = f[j-1] & (f[j-1] << (1 << (j - 1)));
      end
      g = '1;
      for (int b = 0; b < 7; b++) begin
         if (len[b]) begin
            g = f[b] & (g << (1 << b));
         end
      end
      hits = g[127:64];

      tz = 7'd64;
      lz = 7'd64;
      first = '0;
      for (int i = 63; i >= 0; i--) begin
         if (used[i]) begin
            tz = 7'(i);
         end
         if (hits[i]) begin
            first = 6'(i);
         end
      end
      for (int i = 0; i < 64; i++) begin
         if (used[i]) begin
            lz = 7'(63 - i);
         end
      end

      k = {1'b0, len} - {1'b0, carry};
      if (len <= LEN_W'(64)) begin
         res.hit     = |hits;
         res.end_bit = first;
      end else begin
         res.hit     = (len > carry) && (k <= (LEN_W+1)'(64)) && ({7'd0, tz} >= k);
         res.end_bit = 6'(k - 1'b1);
      end
      res.carry = (used == '0) ? (carry + LEN_W'(64)) : {6'd0, lz};
   end

endmodule

/* hw/rtl/bitmap_extent_allocator_core.sv */
// Bitmap first-fit extent allocator core: one used bit per chunk in a word store.
// Sequence: setup checks, then a read and an evaluation per word searched, a read and a
// write per word written, a read and an evaluation per word checked for the full flag, then a hand-over.
// Throughput: one item at a time, set by the single read-modify-write path of the store.
// Reset: a clearing pass zeroes the store's NWORDS words (64 at the default size) at one
// word a cycle with req_stall high; registers return to their reset values.
`include "bitmap_extent_allocator_core_assert.svh"
module bitmap_extent_allocator_core import bea_pkg::*; #(
   parameter int MAX_CHUNKS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_command,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [LEN_W-1:0]  req_length_chunks,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ADDR_W-1:0] rsp_result_address,
   output logic [1:0]        rsp_status,
   output logic              rsp_region_full,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [BASE_W-1:0] csr_write_data
);

   localparam int USE_CHUNKS = (MAX_CHUNKS < 8192) ? MAX_CHUNKS : 8192;
   localparam int NWORDS     = (USE_CHUNKS + WORD_W - 1) / WORD_W;
   localparam int WA         = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   function automatic logic [WORD_W-1:0] ones64(input logic [6:0] n);
      ones64 = n[6] ? '1 : ((64'd1 << n[5:0]) - 64'd1);
   endfunction

   state_type state_ff, state_in;

   logic [BASE_W-1:0] base_ff;
   logic [LEN_W-1:0]  chunks_ff;
   logic [SH_W-1:0]   log2_ff;

   logic [1:0]        cmd_ff, cmd_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  n_ff, n_in;
   logic [WCNT_W-1:0] nw_ff, nw_in;
   logic [WCNT_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0]  carry_ff, carry_in;
   logic [LEN_W-1:0]  start_ff, start_in;
   logic              val_ff, val_in;
   logic              mis_ff, mis_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [1:0]        status_ff, status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              full_ff, full_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_full_ff, rsp_full_in;

   logic [LEN_W-1:0]  n_eff;
   logic [LEN_W:0]    nw_sum;
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] vmask;
   logic [WORD_W-1:0] masked_used;
   fit_res_type       fit_res;
   logic [LEN_W:0]    hit_start;
   logic [32:0]       v33;
   logic [95:0]       shifted;
   logic              addr_fits;
   logic [LEN_W:0]    wend;
   logic [WCNT_W-1:0] first_word;
   logic [WCNT_W-1:0] last_word;
   logic [6:0]        hi_bit;
   logic [6:0]        lo_bit;
   logic [WORD_W-1:0] wmask;
   logic [WORD_W-1:0] wr_word;
   logic [ADDR_W-1:0] lowmask;
   logic [ADDR_W-1:0] rel;
   logic [LEN_W:0]    rel_end;
   logic              chk_bad;
   logic              alloc_bad;
   logic              ptr_last;
   logic              can_load;
   logic              ram_we;
   logic [WORD_W-1:0] ram_wdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         chunks_ff <= LEN_W'(4096);
         log2_ff   <= SH_W'(12);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE:   base_ff   <= csr_write_data;
            CSR_CHUNKS: chunks_ff <= csr_write_data[LEN_W-1:0];
            CSR_LOG2:   log2_ff   <= csr_write_data[SH_W-1:0];
            default: ;
         endcase
      end
   end

   bea_ram #(
      .DEPTH (NWORDS),
      .AW    (WA),
      .DW    (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (WA'(ptr_ff)),
      .wr_data (ram_wdata),
      .rd_addr (WA'(ptr_ff)),
      .rd_data (rd_word)
   );

   bea_fit u_fit (
      .used  (masked_used),
      .carry (carry_ff),
      .len   (len_ff),
      .res   (fit_res)
   );

   always_comb begin
      n_eff = ((MAX_CHUNKS < 8192) && (chunks_ff > LEN_W'(USE_CHUNKS))) ?
              LEN_W'(USE_CHUNKS) : chunks_ff;
      nw_sum = {1'b0, n_eff} + (LEN_W+1)'(63);

      ptr_last = ((ptr_ff + 1'b1) == nw_ff);
      vmask = ((ptr_ff == (nw_ff - 1'b1)) && (n_ff[5:0] != '0)) ?
              ones64({1'b0, n_ff[5:0]}) : '1;
      masked_used = rd_word | ~vmask;

      hit_start = {ptr_ff[6:0], 6'd0} + (LEN_W+1)'(fit_res.end_bit) + 1'b1 - {1'b0, len_ff};

      v33 = {1'b0, base_ff} + 33'(start_ff);
      shifted = 96'(v33) << log2_ff;
      addr_fits = (shifted[95:48] == '0);

      wend = {1'b0, start_ff} + {1'b0, len_ff};
      first_word = {1'b0, start_ff[12:6]};
      last_word = WCNT_W'((wend - 1'b1) >> 6);
      hi_bit = (ptr_ff == last_word) ? 7'(wend - {ptr_ff[6:0], 6'd0}) : 7'd64;
      lo_bit = (ptr_ff == first_word) ? {1'b0, start_ff[5:0]} : 7'd0;
      wmask = ones64(hi_bit) & ~ones64(lo_bit);
      wr_word = val_ff ? (rd_word | wmask) : (rd_word & ~wmask);

      lowmask = (log2_ff >= SH_W'(48)) ? '1 : ((48'd1 << log2_ff) - 48'd1);
      rel = idx_ff - ADDR_W'(base_ff);
      rel_end = {1'b0, rel[LEN_W-1:0]} + {1'b0, len_ff};
      chk_bad = mis_ff || (idx_ff < ADDR_W'(base_ff)) || (rel > ADDR_W'(n_ff)) ||
                (rel_end > {1'b0, n_ff});
      alloc_bad = (len_ff == '0) || (len_ff > n_ff);

      can_load = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == WCNT_W'(NWORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (!alloc_bad) state_in = ST_SRD;
                  else state_in = (n_ff == '0) ? ST_OUT : ST_FRD;
               end
               CMD_FREE, CMD_RESERVE: state_in = ST_CHK2;
               default: state_in = (n_ff == '0) ? ST_OUT : ST_FRD;
            endcase
         end
         ST_CHK2: begin
            if (chk_bad || (len_ff == '0)) state_in = (n_ff == '0) ? ST_OUT : ST_FRD;
            else state_in = ST_WRD;
         end
         ST_SRD: state_in = ST_SEVAL;
         ST_SEVAL: begin
            if (fit_res.hit) state_in = ST_ADDR;
            else if (ptr_last) state_in = ST_FRD;
            else state_in = ST_SRD;
         end
         ST_ADDR: state_in = addr_fits ? ST_WRD : ST_FRD;
         ST_WRD: state_in = ST_WWR;
         ST_WWR: begin
            if (ptr_ff == last_word) state_in = ST_FRD;
            else state_in = ST_WRD;
         end
         ST_FRD: state_in = ST_FEVAL;
         ST_FEVAL: begin
            if ((masked_used != '1) || ptr_last) state_in = ST_OUT;
            else state_in = ST_FRD;
         end
         ST_OUT: begin
            if (can_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and store control
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      ram_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WWR);
      ram_wdata = (state_ff == ST_CLEAR) ? '0 : wr_word;
      rsp_valid          = rsp_valid_ff;
      rsp_result_address = rsp_addr_ff;
      rsp_status         = rsp_status_ff;
      rsp_region_full    = rsp_full_ff;
   end

   // datapath
   always_comb begin
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      n_in        = n_ff;
      nw_in       = nw_ff;
      ptr_in      = ptr_ff;
      carry_in    = carry_ff;
      start_in    = start_ff;
      val_in      = val_ff;
      mis_in      = mis_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      res_addr_in = res_addr_ff;
      full_in     = full_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_full_in   = rsp_full_ff;
      case (state_ff)
         ST_CLEAR: ptr_in = ptr_ff + 1'b1;
         ST_IDLE: begin
            cmd_in      = req_command;
            addr_in     = req_address;
            len_in      = req_length_chunks;
            n_in        = n_eff;
            nw_in       = nw_sum[LEN_W:6];
            status_in   = STAT_OK;
            res_addr_in = '0;
            full_in     = (n_eff == '0);
            ptr_in      = '0;
            carry_in    = '0;
         end
         ST_CHECK: begin
            mis_in = |(addr_ff & lowmask);
            idx_in = addr_ff >> log2_ff;
            if ((cmd_ff == CMD_ALLOC) && alloc_bad) status_in = STAT_NOSPACE;
         end
         ST_CHK2: begin
            if (chk_bad) begin
               status_in = STAT_BAD;
            end else if (len_ff != '0) begin
               start_in = rel[LEN_W-1:0];
               ptr_in   = {1'b0, rel[12:6]};
               val_in   = (cmd_ff == CMD_RESERVE);
            end
         end
         ST_SEVAL: begin
            if (fit_res.hit) begin
               start_in = hit_start[LEN_W-1:0];
            end else if (ptr_last) begin
               status_in = STAT_NOSPACE;
               ptr_in    = '0;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               carry_in = fit_res.carry;
            end
         end
         ST_ADDR: begin
            if (addr_fits) begin
               res_addr_in = shifted[ADDR_W-1:0];
               ptr_in      = first_word;
               val_in      = 1'b1;
            end else begin
               status_in = STAT_BAD;
               ptr_in    = '0;
            end
         end
         ST_WWR: begin
            ptr_in = (ptr_ff == last_word) ? '0 : (ptr_ff + 1'b1);
         end
         ST_FEVAL: begin
            if (masked_used != '1) full_in = 1'b0;
            else if (ptr_last) full_in = 1'b1;
            else ptr_in = ptr_ff + 1'b1;
         end
         ST_OUT: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = (status_ff == STAT_OK) ? res_addr_ff : '0;
               rsp_status_in = status_ff;
               rsp_full_in   = full_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      n_ff          <= n_in;
      nw_ff         <= nw_in;
      carry_ff      <= carry_in;
      start_ff      <= start_in;
      val_ff        <= val_in;
      mis_ff        <= mis_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      res_addr_ff   <= res_addr_in;
      full_ff       <= full_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_full_ff   <= rsp_full_in;
   end

   `BEA_ASSERT_NEXT(a_clear_once, clock, reset, state_ff != ST_CLEAR, state_ff != ST_CLEAR)
   `BEA_ASSERT_NEXT(a_accept_check, clock, reset, req_valid && !req_stall, state_ff == ST_CHECK)
   `BEA_ASSERT_IMP(a_wr_range, clock, reset, state_ff == ST_WWR, (ptr_ff >= first_word) && (ptr_ff <= last_word))
   `BEA_ASSERT_IMP(a_hit_len, clock, reset, (state_ff == ST_SEVAL) && fit_res.hit, (len_ff != '0) && (len_ff <= n_ff))

endmodule

/* bench/tb.sv */
// Self-checking testbench for the bitmap first-fit extent allocator core.
module tb;
   import bea_pkg::*;

   localparam int NCHUNK = 4096;
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [47:0] addr;
      logic [1:0]  status;
      logic        full;
   } rsp_t;

   typedef struct {
      logic [1:0]  cmd;
      logic [47:0] addr;
      logic [12:0] len;
      bit          typed;
      rsp_t        want;
   } row_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_command = CMD_ALLOC;
   logic [ADDR_W-1:0] req_address = '0;
   logic [LEN_W-1:0]  req_length_chunks = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ADDR_W-1:0] rsp_result_address;
   logic [1:0]        rsp_status;
   logic              rsp_region_full;
   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index = CSR_BASE;
   logic [BASE_W-1:0] csr_write_data = '0;

   bitmap_extent_allocator_core #(.MAX_CHUNKS(NCHUNK)) uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   bit                chunk_busy [NCHUNK];
   longint unsigned   base_chunk = 0;
   longint unsigned   num_chunks = 4096;
   longint unsigned   size_log2 = 12;

   rsp_t  owed_results[$];
   row_t  typed_rows[$];
   int    errors = 0;
   int    accepted = 0;
   logic  hold_long = 1'b0;
   int    stall_pct = 0;
   int    stall_age = 0;

   task automatic report(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
   endtask

   function automatic longint unsigned live_chunks();
      return num_chunks < NCHUNK ? num_chunks : NCHUNK;
   endfunction

   function automatic bit region_all_busy();
      longint unsigned n;
      n = live_chunks();
      for (longint unsigned i = 0; i < n; i++)
         if (!chunk_busy[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void mark_run(longint unsigned start, longint unsigned len, bit val);
      for (longint unsigned i = 0; i < len; i++)
         if (start + i < NCHUNK) chunk_busy[start + i] = val;
   endfunction

   function automatic logic [1:0] run_update(logic [47:0] addr, longint unsigned len,
                                            bit val);
      longint unsigned low, idx, rel, n;
      n = live_chunks();
      low = (64'd1 << size_log2) - 1;
      if ((longint'(addr) & low) != 0) return STAT_BAD;
      idx = longint'(addr) >> size_log2;
      if (idx < base_chunk) return STAT_BAD;
      rel = idx - base_chunk;
      if (rel > n || len > n - rel) return STAT_BAD;
      mark_run(rel, len, val);
      return STAT_OK;
   endfunction

   function automatic rsp_t predict_alloc_result(logic [1:0] cmd, logic [47:0] addr,
                                                logic [12:0] len_in);
      rsp_t r;
      longint unsigned n, len, run, start, v;
      bit hit;
      r.addr = '0;
      r.status = STAT_OK;
      n = live_chunks();
      len = len_in;
      hit = 1'b0;
      run = 0;
      start = 0;
      case (cmd)
         CMD_ALLOC: begin
            if (len != 0 && len <= n) begin
               for (longint unsigned i = 0; i < n && !hit; i++) begin
                  if (chunk_busy[i]) run = 0;
                  else begin
                     run++;
                     if (run == len) begin
                        hit = 1'b1;
                        start = i + 1 - len;
                     end
                  end
               end
            end
            if (!hit) r.status = STAT_NOSPACE;
            else begin
               v = base_chunk + start;
               if (size_log2 >= 48 ? v != 0 : (v >> (48 - size_log2)) != 0)
                  r.status = STAT_BAD;
               else begin
                  mark_run(start, len, 1'b1);
                  r.addr = (v << size_log2) & M48;
               end
            end
         end
         CMD_FREE:    r.status = run_update(addr, len, 1'b0);
         CMD_RESERVE: r.status = run_update(addr, len, 1'b1);
         default: ;
      endcase
      r.full = region_all_busy();
      return r;
   endfunction

   // input side: predict on every accepted item
   always @(posedge clock) begin
      rsp_t p;
      row_t t;
      if (!reset && req_valid && !req_stall) begin
         p = predict_alloc_result(req_command, req_address, req_length_chunks);
         t = typed_rows.pop_front();
         owed_results.push_back(t.typed ? t.want : p);
         accepted++;
      end
   end

   // output side
   always @(posedge clock) begin
      rsp_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) report("unexpected item", rsp_result_address, '0);
         else begin
            w = owed_results.pop_front();
            if (rsp_result_address !== w.addr) report("address", rsp_result_address, w.addr);
            if (rsp_status !== w.status) report("status", rsp_status, w.status);
            if (rsp_region_full !== w.full) report("full", rsp_region_full, w.full);
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (stall_age == 0) begin
         stall_age <= $urandom_range(20, 200);
         stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 80);
      end else stall_age <= stall_age - 1;
      rsp_stall <= hold_long || ($urandom_range(0, 99) < stall_pct);
   end

   // long receiver hold-off while requests keep being offered
   initial begin
      wait (accepted >= 420);
      @(posedge clock);
      hold_long <= 1'b1;
      repeat (2000) @(posedge clock);
      hold_long <= 1'b0;
   end

   task automatic send(logic [1:0] cmd, logic [47:0] addr, logic [12:0] len, bit typed,
                       rsp_t want);
      row_t t;
      t.cmd = cmd; t.addr = addr; t.len = len; t.typed = typed; t.want = want;
      typed_rows.push_back(t);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      req_length_chunks <= len;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      pause(1);
      wait (owed_results.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_region(logic [31:0] b, logic [12:0] n, logic [5:0] sh);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_BASE;   csr_write_data <= b;       @(posedge clock);
      csr_index <= CSR_CHUNKS; csr_write_data <= 32'(n);  @(posedge clock);
      csr_index <= CSR_LOG2;   csr_write_data <= 32'(sh); @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      base_chunk = b; num_chunks = n; size_log2 = sh;
   endtask

   task automatic random_items(int count);
      int burst;
      logic [1:0] cmd;
      logic [47:0] addr;
      logic [12:0] len;
      longint unsigned n, idx;
      rsp_t none;
      none = '{default: '0};
      burst = 0;
      for (int k = 0; k < count; k++) begin
         n = live_chunks();
         case ($urandom_range(0, 19))
            0:          cmd = CMD_NONE;
            1,2,3,4,5,6,7,8: cmd = CMD_ALLOC;
            9,10,11,12,13,14: cmd = CMD_FREE;
            default:    cmd = CMD_RESERVE;
         endcase
         if ($urandom_range(0, 9) == 0) len = 13'($urandom_range(0, 4096));
         else if ($urandom_range(0, 3) == 0) len = 13'($urandom_range(0, n));
         else len = 13'($urandom_range(0, n < 8 ? n : 8));
         if ($urandom_range(0, 4) == 0) addr = 48'({$urandom, $urandom});
         else begin
            idx = base_chunk + $urandom_range(0, n);
            addr = 48'(idx << size_log2);
         end
         send(cmd, addr, len, 1'b0, none);
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30));
         end else burst--;
      end
   endtask

   row_t rows[] = '{
      '{CMD_ALLOC,   48'h0,              13'd0,    1, '{48'h0, STAT_NOSPACE, 1'b0}},
      '{CMD_ALLOC,   48'h0,              13'd1,    1, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_ALLOC,   48'h0,              13'd4096, 1, '{48'h0, STAT_NOSPACE, 1'b0}},
      '{CMD_FREE,    48'h0,              13'd1,    1, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_ALLOC,   M48,                13'd4096, 1, '{48'h0, STAT_OK,      1'b1}},
      '{CMD_FREE,    48'h123,            13'd1,    1, '{48'h0, STAT_BAD,     1'b1}},
      '{CMD_FREE,    48'h100_0000,       13'd1,    1, '{48'h0, STAT_BAD,     1'b1}},
      '{CMD_FREE,    48'h100_0000,       13'd0,    1, '{48'h0, STAT_OK,      1'b1}},
      '{CMD_FREE,    48'h0,              13'd4096, 1, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_NONE,    M48,                13'd4096, 1, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_RESERVE, 48'hFF_F000,        13'd1,    1, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_RESERVE, M48,                13'd4096, 1, '{48'h0, STAT_BAD,     1'b0}},
      '{CMD_RESERVE, 48'hFFFF_FFFF_F000, 13'd1,    1, '{48'h0, STAT_BAD,     1'b0}},
      '{CMD_ALLOC,   M48,                13'd4095, 1, '{48'h0, STAT_OK,      1'b1}},
      '{CMD_FREE,    48'h0,              13'd4096, 1, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_ALLOC,   48'h0,              13'd3,    0, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_ALLOC,   48'h0,              13'd5,    0, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_FREE,    48'h1000,           13'd2,    0, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_ALLOC,   48'h0,              13'd2,    0, '{48'h0, STAT_OK,      1'b0}},
      '{CMD_RESERVE, 48'hAAAA_AAAA_A000, 13'd2730, 0, '{48'h0, STAT_OK,      1'b0}}
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         send(rows[i].cmd, rows[i].addr, rows[i].len, rows[i].typed, rows[i].want);
         if (i % 4 == 3) pause($urandom_range(1, 6));
      end
      drain();
      set_region(32'd0, 13'd16, 6'd0);              random_items(150);
      drain();
      set_region(32'hFFFF_FFFF, 13'd8, 6'd40);      random_items(60);
      drain();
      set_region(32'd5, 13'd1, 6'd40);              random_items(60);
      drain();
      set_region(32'h123, 13'd64, 6'd3);            random_items(220);
      drain();
      set_region(32'h8000_0000, 13'd33, 6'd7);      random_items(150);
      drain();
      set_region(32'h00FF_FFF0, 13'd100, 6'd20);    random_items(150);
      drain();
      set_region(32'd0, 13'd4096, 6'd12);           random_items(140);
      pause(1);
      wait (owed_results.size() == 0);
      repeat (500) @(posedge clock);
      if (errors == 0 && typed_rows.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bea_pkg.sv
hw/rtl/bea_ram.sv
hw/rtl/bea_fit.sv
hw/rtl/bitmap_extent_allocator_core.sv
bench/tb.sv
